@@ rtl/core/totp_pkg.sv @@
// Shared constants and functions for the TOTP code generator.
// Holds the SHA-1 round and schedule functions and the code alphabet.
// Has no dependencies.
package totp_pkg;

  localparam int KEY_WORDS = 5;
  localparam int SIDE_W    = 161;
  localparam int CFG_AW    = 3;

  localparam logic [CFG_AW-1:0] CFG_KEY_W0      = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_KEY_W1      = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_KEY_W2      = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_KEY_W3      = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_KEY_W4      = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_KEY_PRESENT = 3'd5;

  localparam logic [159:0] SHA1_IV =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
  localparam logic [511:0] IPAD = {64{8'h36}};
  localparam logic [511:0] OPAD = {64{8'h5C}};
  localparam logic [63:0]  INNER_LEN_BITS = 64'd576;
  localparam logic [63:0]  OUTER_LEN_BITS = 64'd672;
  localparam logic [31:0]  PAD_WORD = 32'h8000_0000;

  // Reciprocals for x / 15 and x / 13 on 30-bit values, shifted by 34.
  localparam logic [30:0] DIV15_MAGIC = 31'd1145324613;
  localparam logic [30:0] DIV13_MAGIC = 31'd1321528399;

  function automatic logic [159:0] sha1_round(input logic [6:0] idx,
                                              input logic [159:0] st,
                                              input logic [31:0] w);
    logic [31:0] a, b, c, d, e, f, k, t;
    a = st[159:128];
    b = st[127:96];
    c = st[95:64];
    d = st[63:32];
    e = st[31:0];
    if (idx < 7'd20) begin
      f = (b & c) | (~b & d);
      k = 32'h5A827999;
    end else if (idx < 7'd40) begin
      f = b ^ c ^ d;
      k = 32'h6ED9EBA1;
    end else if (idx < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d;
      k = 32'hCA62C1D6;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w;
    return {t, a, {b[1:0], b[31:2]}, c, d};
  endfunction

  function automatic logic [31:0] sha1_sched(input logic [511:0] win);
    logic [31:0] x;
    x = win[511:480] ^ win[447:416] ^ win[255:224] ^ win[95:64];
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [6:0] code_char(input logic [4:0] dig);
    logic [6:0] ch;
    unique case (dig)
      5'd0:    ch = 7'h32;
      5'd1:    ch = 7'h33;
      5'd2:    ch = 7'h34;
      5'd3:    ch = 7'h35;
      5'd4:    ch = 7'h36;
      5'd5:    ch = 7'h37;
      5'd6:    ch = 7'h38;
      5'd7:    ch = 7'h39;
      5'd8:    ch = 7'h42;
      5'd9:    ch = 7'h43;
      5'd10:   ch = 7'h44;
      5'd11:   ch = 7'h46;
      5'd12:   ch = 7'h47;
      5'd13:   ch = 7'h48;
      5'd14:   ch = 7'h4A;
      5'd15:   ch = 7'h4B;
      5'd16:   ch = 7'h4D;
      5'd17:   ch = 7'h4E;
      5'd18:   ch = 7'h50;
      5'd19:   ch = 7'h51;
      5'd20:   ch = 7'h52;
      5'd21:   ch = 7'h54;
      5'd22:   ch = 7'h56;
      5'd23:   ch = 7'h57;
      5'd24:   ch = 7'h58;
      5'd25:   ch = 7'h59;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/totp_sha1_blk.sv @@
// One SHA-1 compression as an 80-stage round pipeline plus a final add stage.
// The message schedule travels as a 16-word window beside each round.
// Depends on totp_pkg.
module totp_sha1_blk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [159:0]                h_i,
  input  logic [511:0]                blk_i,
  input  logic [totp_pkg::SIDE_W-1:0] side_i,
  output logic                        vld_o,
  output logic [159:0]                h_o,
  output logic [totp_pkg::SIDE_W-1:0] side_o
);

  logic                        vld_r  [0:79];
  logic [159:0]                st_r   [0:79];
  logic [159:0]                h_r    [0:79];
  logic [511:0]                win_r  [0:79];
  logic [totp_pkg::SIDE_W-1:0] side_r [0:79];

  logic                        fin_vld_r;
  logic [159:0]                fin_h_r;
  logic [totp_pkg::SIDE_W-1:0] fin_side_r;
  logic [159:0]                fin_h_nxt;

  for (genvar g = 0; g < 80; g++) begin : g_rnd
    logic                        v_src;
    logic [159:0]                st_src;
    logic [159:0]                h_src;
    logic [511:0]                win_src;
    logic [totp_pkg::SIDE_W-1:0] sd_src;

    if (g == 0) begin : g_first
      assign v_src   = vld_i;
      assign st_src  = h_i;
      assign h_src   = h_i;
      assign win_src = blk_i;
      assign sd_src  = side_i;
    end else begin : g_next
      assign v_src   = vld_r[g-1];
      assign st_src  = st_r[g-1];
      assign h_src   = h_r[g-1];
      assign win_src = win_r[g-1];
      assign sd_src  = side_r[g-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g]   <= totp_pkg::sha1_round(7'(g), st_src, win_src[511:480]);
        win_r[g]  <= {win_src[479:0], totp_pkg::sha1_sched(win_src)};
        h_r[g]    <= h_src;
        side_r[g] <= sd_src;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      fin_h_nxt[32*i +: 32] = h_r[79][32*i +: 32] + st_r[79][32*i +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= vld_r[79];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_h_r    <= fin_h_nxt;
      fin_side_r <= side_r[79];
    end
  end

  assign vld_o  = fin_vld_r;
  assign h_o    = fin_h_r;
  assign side_o = fin_side_r;

endmodule

@@ rtl/core/totp_b26.sv @@
// Dynamic truncation of the HMAC digest and five base-26 digit stages.
// The last digit stage is the output register of the block.
// Depends on totp_pkg.
module totp_b26 (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_i,
  input  logic [159:0] dig_i,
  input  logic         nokey_i,
  output logic         vld_o,
  output logic [34:0]  code_o,
  output logic [30:0]  val_o,
  output logic         nokey_o
);

  logic         tr_vld_r;
  logic [30:0]  tr_val_r;
  logic         tr_nk_r;
  logic [159:0] tr_sh;

  logic         dg_vld_r [0:4];
  logic [30:0]  dg_rem_r [0:4];
  logic [30:0]  dg_val_r [0:4];
  logic [34:0]  dg_chr_r [0:4];
  logic         dg_nk_r  [0:4];

  assign tr_sh = dig_i << {dig_i[3:0], 3'b000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tr_vld_r <= 1'b0;
    end else if (en) begin
      tr_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tr_val_r <= tr_sh[158:128];
      tr_nk_r  <= nokey_i;
    end
  end

  for (genvar g = 0; g < 5; g++) begin : g_dig
    logic        v_src;
    logic [30:0] rem_src;
    logic [30:0] val_src;
    logic [34:0] chr_src;
    logic        nk_src;
    logic [60:0] prod;
    logic [26:0] quo;
    logic [30:0] left;
    logic [34:0] chr_nxt;

    if (g == 0) begin : g_first
      assign v_src   = tr_vld_r;
      assign rem_src = tr_val_r;
      assign val_src = tr_val_r;
      assign chr_src = '0;
      assign nk_src  = tr_nk_r;
    end else begin : g_next
      assign v_src   = dg_vld_r[g-1];
      assign rem_src = dg_rem_r[g-1];
      assign val_src = dg_val_r[g-1];
      assign chr_src = dg_chr_r[g-1];
      assign nk_src  = dg_nk_r[g-1];
    end

    assign prod = 61'(rem_src[30:1]) * 61'(totp_pkg::DIV13_MAGIC);
    assign quo  = prod[60:34];
    assign left = rem_src - 31'(quo) * 31'd26;

    always_comb begin
      chr_nxt = chr_src;
      chr_nxt[7*g +: 7] = totp_pkg::code_char(left[4:0]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dg_vld_r[g] <= 1'b0;
      end else if (en) begin
        dg_vld_r[g] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dg_rem_r[g] <= 31'(quo);
        dg_val_r[g] <= val_src;
        dg_chr_r[g] <= chr_nxt;
        dg_nk_r[g]  <= nk_src;
      end
    end
  end

  assign vld_o   = dg_vld_r[4];
  assign nokey_o = dg_nk_r[4];
  assign code_o  = dg_nk_r[4] ? 35'd0 : dg_chr_r[4];
  assign val_o   = dg_nk_r[4] ? 31'd0 : dg_val_r[4];

endmodule

@@ rtl/core/totp_hmac_sha1_base26_code_top.sv @@
// Each transfer takes one time stamp and yields one five-character code, the truncated
// HMAC-SHA1 value and a missing-key flag. One item enters every cycle unless the pipeline
// holds; it runs through one divide stage, three SHA-1 compressions of 81 stages each
// (the inner and outer key blocks run side by side), one truncation stage and five
// digit stages. The whole pipeline holds while a result waits on out_tready.
// Depends on totp_pkg, totp_sha1_blk and totp_b26.
module totp_hmac_sha1_base26_code_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // unix_seconds[30:0], zero pad
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [71:0]                 out_tdata,  // char0..char4, truncated_value, pad
  output logic                        out_tuser,  // no_key_error
  input  logic                        cfg_we,
  input  logic [totp_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [31:0]                 cfg_wdata
);

  logic [159:0] key_r;
  logic         key_present_r;
  logic         en;

  logic [60:0]  div_prod;
  logic         s0_vld_r;
  logic [26:0]  s0_cnt_r;
  logic         s0_nk_r;

  logic [159:0] ik_h;
  logic [159:0] ok_h;
  logic         ik_vld;
  logic [totp_pkg::SIDE_W-1:0] ik_side;
  logic [511:0] ik_blk;
  logic [511:0] ok_blk;

  logic         in_vld;
  logic [159:0] in_h;
  logic [totp_pkg::SIDE_W-1:0] in_side;

  logic         ou_vld;
  logic [159:0] ou_h;
  logic [totp_pkg::SIDE_W-1:0] ou_side;

  logic         res_vld;
  logic [34:0]  res_code;
  logic [30:0]  res_val;
  logic         res_nk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r         <= '0;
      key_present_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        totp_pkg::CFG_KEY_W0:      key_r[159:128] <= cfg_wdata;
        totp_pkg::CFG_KEY_W1:      key_r[127:96]  <= cfg_wdata;
        totp_pkg::CFG_KEY_W2:      key_r[95:64]   <= cfg_wdata;
        totp_pkg::CFG_KEY_W3:      key_r[63:32]   <= cfg_wdata;
        totp_pkg::CFG_KEY_W4:      key_r[31:0]    <= cfg_wdata;
        totp_pkg::CFG_KEY_PRESENT: key_present_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign en        = !res_vld || out_tready;
  assign in_tready = en;

  // The time step is (t >> 1) / 15 through a reciprocal multiply.
  assign div_prod = 61'(in_tdata[30:1]) * 61'(totp_pkg::DIV15_MAGIC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_cnt_r <= div_prod[60:34];
      s0_nk_r  <= !key_present_r;
    end
  end

  assign ik_blk = {key_r, 352'd0} ^ totp_pkg::IPAD;
  assign ok_blk = {key_r, 352'd0} ^ totp_pkg::OPAD;

  totp_sha1_blk u_ikey (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (s0_vld_r),
    .h_i    (totp_pkg::SHA1_IV),
    .blk_i  (ik_blk),
    .side_i ({s0_nk_r, 128'd0, 32'(s0_cnt_r)}),
    .vld_o  (ik_vld),
    .h_o    (ik_h),
    .side_o (ik_side)
  );

  totp_sha1_blk u_okey (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (s0_vld_r),
    .h_i    (totp_pkg::SHA1_IV),
    .blk_i  (ok_blk),
    .side_i ('0),
    .vld_o  (),
    .h_o    (ok_h),
    .side_o ()
  );

  totp_sha1_blk u_inner (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (ik_vld),
    .h_i    (ik_h),
    .blk_i  ({32'd0, ik_side[31:0], totp_pkg::PAD_WORD, 352'd0,
              totp_pkg::INNER_LEN_BITS}),
    .side_i ({ik_side[160], ok_h}),
    .vld_o  (in_vld),
    .h_o    (in_h),
    .side_o (in_side)
  );

  totp_sha1_blk u_outer (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_vld),
    .h_i    (in_side[159:0]),
    .blk_i  ({in_h, totp_pkg::PAD_WORD, 256'd0, totp_pkg::OUTER_LEN_BITS}),
    .side_i ({in_side[160], 160'd0}),
    .vld_o  (ou_vld),
    .h_o    (ou_h),
    .side_o (ou_side)
  );

  totp_b26 u_b26 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (ou_vld),
    .dig_i   (ou_h),
    .nokey_i (ou_side[160]),
    .vld_o   (res_vld),
    .code_o  (res_code),
    .val_o   (res_val),
    .nokey_o (res_nk)
  );

  assign out_tvalid = res_vld;
  assign out_tdata  = {6'd0, res_val, res_code};
  assign out_tuser  = res_nk;

endmodule

@@ rtl/core/totp_chk.sv @@
// Port-level checker for the TOTP code generator, bound to the top level.
// Does not depend on totp_pkg; its port widths are given directly.
module totp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output backpressure");

  a_nokey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 72'd0)
    else $error("fields not cleared on missing key");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[6:0] >= 7'd50 && out_tdata[6:0] <= 7'd89 &&
      out_tdata[34:28] >= 7'd50 && out_tdata[34:28] <= 7'd89)
    else $error("code character outside alphabet");

endmodule

bind totp_hmac_sha1_base26_code_top totp_chk u_totp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
